// File: sv/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// shared constants and types of the 3x3 matrix inverse unit
// ----------------------------------------------------------------------------
`default_nettype none

package mi3_pkg;

  localparam int ELEM_WIDTH_DEF = 16;
  localparam int NLANE          = 9;
  localparam int OUT_WIDTH      = 32;
  localparam int OUT_FRAC       = 16;
  localparam int QUOT_WIDTH     = OUT_WIDTH + 1;

  localparam logic [OUT_WIDTH-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [OUT_WIDTH-1:0] SAT_NEG = 32'h8000_0000;

  // cofactor row*3+col = m[i0]*m[i1] - m[i2]*m[i3], entries a..i as 0..8
  localparam logic [3:0] COF_IDX [NLANE][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  typedef struct packed {
    logic [NLANE-1:0] neg;
    logic             sing;
  } div_tag_t;

endpackage

`default_nettype wire

// File: sv/matrix_inverse_3x3_unit.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_unit
// 3x3 matrix inverse by adjugate over determinant, Q8.8 in, Q16.16 out
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// in_       input      in_valid/in_stall    in_m00 .. in_m22
// out_      output     out_valid/out_stall  out_r00 .. out_r22, out_singular
//
// one matrix per cycle while the pipeline does not stall; stages: products,
// cofactors, determinant products, determinant sum, magnitudes, 33 divider stages
// (one quotient bit each) and the saturating output register
// each stage holds while the next is full and stalled, so bubbles collapse
// reset clears only the valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_inverse_3x3_unit #(
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [ELEM_WIDTH-1:0]  in_m00,
  input  wire logic signed [ELEM_WIDTH-1:0]  in_m01,
  input  wire logic signed [ELEM_WIDTH-1:0]  in_m02,
  input  wire logic signed [ELEM_WIDTH-1:0]  in_m10,
  input  wire logic signed [ELEM_WIDTH-1:0]  in_m11,
  input  wire logic signed [ELEM_WIDTH-1:0]  in_m12,
  input  wire logic signed [ELEM_WIDTH-1:0]  in_m20,
  input  wire logic signed [ELEM_WIDTH-1:0]  in_m21,
  input  wire logic signed [ELEM_WIDTH-1:0]  in_m22,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [31:0]                 out_r00,
  output logic signed [31:0]                 out_r01,
  output logic signed [31:0]                 out_r02,
  output logic signed [31:0]                 out_r10,
  output logic signed [31:0]                 out_r11,
  output logic signed [31:0]                 out_r12,
  output logic signed [31:0]                 out_r20,
  output logic signed [31:0]                 out_r21,
  output logic signed [31:0]                 out_r22,
  output logic                               out_singular
);

  localparam int W   = ELEM_WIDTH;
  localparam int F   = W / 2;
  localparam int QW  = mi3_pkg::QUOT_WIDTH;
  localparam int OW  = mi3_pkg::OUT_WIDTH;
  localparam int NL  = mi3_pkg::NLANE;
  localparam int NW  = 2 * W + F + mi3_pkg::OUT_FRAC;
  localparam int DW  = 3 * W;
  localparam int DSW = 3 * W + 3;
  localparam int DIV0 = 5;
  localparam int NS  = DIV0 + QW + 1;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        v_nxt[k] = (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NS-1];

  logic signed [W-1:0] m_in [NL];
  assign m_in[0] = in_m00;
  assign m_in[1] = in_m01;
  assign m_in[2] = in_m02;
  assign m_in[3] = in_m10;
  assign m_in[4] = in_m11;
  assign m_in[5] = in_m12;
  assign m_in[6] = in_m20;
  assign m_in[7] = in_m21;
  assign m_in[8] = in_m22;

  // products
  logic signed [2*W-1:0] p0_r  [NL];
  logic signed [2*W-1:0] p1_r  [NL];
  logic signed [W-1:0]   abc_r0 [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int c = 0; c < NL; c++) begin
        p0_r[c] <= m_in[mi3_pkg::COF_IDX[c][0]] * m_in[mi3_pkg::COF_IDX[c][1]];
        p1_r[c] <= m_in[mi3_pkg::COF_IDX[c][2]] * m_in[mi3_pkg::COF_IDX[c][3]];
      end
      for (int j = 0; j < 3; j++) begin
        abc_r0[j] <= m_in[j];
      end
    end
  end

  // cofactors
  logic signed [2*W:0] cof_r1 [NL];
  logic signed [W-1:0] abc_r1 [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int c = 0; c < NL; c++) begin
        cof_r1[c] <= {p0_r[c][2*W-1], p0_r[c]} - {p1_r[c][2*W-1], p1_r[c]};
      end
      abc_r1 <= abc_r0;
    end
  end

  // determinant products along the first row
  logic signed [3*W:0] dp_r2  [3];
  logic signed [2*W:0] cof_r2 [NL];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int j = 0; j < 3; j++) begin
        dp_r2[j] <= abc_r1[j] * cof_r1[j];
      end
      cof_r2 <= cof_r1;
    end
  end

  // determinant sum
  logic signed [DSW-1:0] det_r3;
  logic signed [2*W:0]   cof_r3 [NL];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      det_r3 <= {{2{dp_r2[0][3*W]}}, dp_r2[0]} + {{2{dp_r2[1][3*W]}}, dp_r2[1]}
              + {{2{dp_r2[2][3*W]}}, dp_r2[2]};
      cof_r3 <= cof_r2;
    end
  end

  // magnitudes and signs, lane r*3+k takes cofactor k*3+r
  logic [NW-1:0]     n_r4 [NL];
  logic [DW-1:0]     d_r4;
  mi3_pkg::div_tag_t tag_r4;
  logic [NW-1:0]     n_nxt [NL];
  logic [DW-1:0]     d_nxt;
  mi3_pkg::div_tag_t tag_nxt;

  always_comb begin
    logic signed [2*W:0]   cv;
    logic        [2*W:0]   cmag;
    logic        [DSW-1:0] dmag;
    dmag = det_r3[DSW-1] ? DSW'(-det_r3) : DSW'(det_r3);
    d_nxt = dmag[DW-1:0];
    tag_nxt.sing = (det_r3 == '0);
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        cv = cof_r3[k*3+r];
        cmag = cv[2*W] ? (2*W+1)'(-cv) : (2*W+1)'(cv);
        n_nxt[r*3+k] = {cmag[2*W-1:0], {(F + mi3_pkg::OUT_FRAC){1'b0}}};
        tag_nxt.neg[r*3+k] = cv[2*W] ^ det_r3[DSW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      n_r4   <= n_nxt;
      d_r4   <= d_nxt;
      tag_r4 <= tag_nxt;
    end
  end

  logic [QW-1:0]     q_dv   [NL];
  logic              ovf_dv [NL];
  mi3_pkg::div_tag_t tag_dv;

  mi3_div_pipe #(
    .NW (NW),
    .DW (DW),
    .QW (QW)
  ) u_div (
    .clk     (clk),
    .en      (en[DIV0 +: QW]),
    .n_in    (n_r4),
    .d_in    (d_r4),
    .tag_in  (tag_r4),
    .q_out   (q_dv),
    .ovf_out (ovf_dv),
    .tag_out (tag_dv)
  );

  // saturation and output register
  logic [OW-1:0] res_r [NL];
  logic          sing_r;
  logic [OW-1:0] res_nxt [NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      if (tag_dv.sing) begin
        res_nxt[l] = '0;
      end else if (tag_dv.neg[l]) begin
        if (ovf_dv[l] || q_dv[l] > QW'(mi3_pkg::SAT_NEG)) begin
          res_nxt[l] = mi3_pkg::SAT_NEG;
        end else begin
          res_nxt[l] = OW'(0) - q_dv[l][OW-1:0];
        end
      end else begin
        if (ovf_dv[l] || q_dv[l] > QW'(mi3_pkg::SAT_POS)) begin
          res_nxt[l] = mi3_pkg::SAT_POS;
        end else begin
          res_nxt[l] = q_dv[l][OW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      res_r  <= res_nxt;
      sing_r <= tag_dv.sing;
    end
  end

  assign out_r00      = res_r[0];
  assign out_r01      = res_r[1];
  assign out_r02      = res_r[2];
  assign out_r10      = res_r[3];
  assign out_r11      = res_r[4];
  assign out_r12      = res_r[5];
  assign out_r20      = res_r[6];
  assign out_r21      = res_r[7];
  assign out_r22      = res_r[8];
  assign out_singular = sing_r;

endmodule

`default_nettype wire

// File: sv/mi3_div_pipe.sv
// ----------------------------------------------------------------------------
// mi3_div_pipe
// nine-lane restoring divider, one quotient bit per stage, shared divisor
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_div_pipe #(
  parameter int NW = 56,
  parameter int DW = 48,
  parameter int QW = mi3_pkg::QUOT_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic [QW-1:0]        en,
  input  wire logic [NW-1:0]        n_in    [mi3_pkg::NLANE],
  input  wire logic [DW-1:0]        d_in,
  input  wire mi3_pkg::div_tag_t    tag_in,
  output logic      [QW-1:0]        q_out   [mi3_pkg::NLANE],
  output logic                      ovf_out [mi3_pkg::NLANE],
  output mi3_pkg::div_tag_t         tag_out
);

  localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [NW-1:0]     rem_r [QW][mi3_pkg::NLANE];
  logic [QW-1:0]     q_r   [QW][mi3_pkg::NLANE];
  logic              ovf_r [QW][mi3_pkg::NLANE];
  logic [DW-1:0]     d_r   [QW];
  mi3_pkg::div_tag_t tag_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_st
    logic [NW-1:0]     rem_i   [mi3_pkg::NLANE];
    logic [QW-1:0]     q_i     [mi3_pkg::NLANE];
    logic              ovf_i   [mi3_pkg::NLANE];
    logic [DW-1:0]     d_i;
    mi3_pkg::div_tag_t tag_i;
    logic [NW-1:0]     rem_nxt [mi3_pkg::NLANE];
    logic [QW-1:0]     q_nxt   [mi3_pkg::NLANE];

    if (s == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < mi3_pkg::NLANE; l++) begin
          rem_i[l] = n_in[l];
          q_i[l]   = '0;
          ovf_i[l] = CW'(n_in[l]) >= (CW'(d_in) << QW);
        end
        d_i   = d_in;
        tag_i = tag_in;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < mi3_pkg::NLANE; l++) begin
          rem_i[l] = rem_r[s-1][l];
          q_i[l]   = q_r[s-1][l];
          ovf_i[l] = ovf_r[s-1][l];
        end
        d_i   = d_r[s-1];
        tag_i = tag_r[s-1];
      end
    end

    always_comb begin
      logic [CW-1:0] dsh;
      logic [CW-1:0] rin;
      dsh = CW'(d_i) << (QW - 1 - s);
      for (int l = 0; l < mi3_pkg::NLANE; l++) begin
        rin = CW'(rem_i[l]);
        if (rin >= dsh) begin
          rem_nxt[l] = NW'(rin - dsh);
          q_nxt[l]   = q_i[l] | (QW'(1) << (QW - 1 - s));
        end else begin
          rem_nxt[l] = rem_i[l];
          q_nxt[l]   = q_i[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        for (int l = 0; l < mi3_pkg::NLANE; l++) begin
          rem_r[s][l] <= rem_nxt[l];
          q_r[s][l]   <= q_nxt[l];
          ovf_r[s][l] <= ovf_i[l];
        end
        d_r[s]   <= d_i;
        tag_r[s] <= tag_i;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < mi3_pkg::NLANE; l++) begin
      q_out[l]   = q_r[QW-1][l];
      ovf_out[l] = ovf_r[QW-1][l] | (|rem_r[QW-1][l] & 1'b0);
    end
    tag_out = tag_r[QW-1];
  end

endmodule

`default_nettype wire

// File: tb/sv/tb_matrix_inverse_3x3_unit.sv
// ----------------------------------------------------------------------------
// tb_matrix_inverse_3x3_unit
// streams 3x3 Q8.8 matrices through the inverse unit and checks every Q16.16
// inverse entry and the singular flag against an exact adjugate predictor
// ----------------------------------------------------------------------------
`default_nettype none

module tb_matrix_inverse_3x3_unit;

  localparam int EW        = mi3_pkg::ELEM_WIDTH_DEF;
  localparam int FRAC      = EW / 2;
  localparam int NRAND     = 900;
  localparam int LATENCY   = 39;
  localparam int CYC_LIMIT = 400000;

  typedef logic signed [EW-1:0] elem_t;
  typedef elem_t mat_t [9];

  typedef struct {
    logic [31:0] r [9];
    logic        sing;
  } inv_t;

  typedef struct {
    mat_t m;
    bit   known;
    inv_t res;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  elem_t in_m [9];
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_r [9];
  logic out_singular;

  inv_t inv_queue [$];
  inv_t known_queue [$];
  bit   known_flag [$];
  int   fails;
  int   cycles;
  bit   stim_done;

  matrix_inverse_3x3_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_m00(in_m[0]), .in_m01(in_m[1]), .in_m02(in_m[2]),
    .in_m10(in_m[3]), .in_m11(in_m[4]), .in_m12(in_m[5]),
    .in_m20(in_m[6]), .in_m21(in_m[7]), .in_m22(in_m[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_r00(out_r[0]), .out_r01(out_r[1]), .out_r02(out_r[2]),
    .out_r10(out_r[3]), .out_r11(out_r[4]), .out_r12(out_r[5]),
    .out_r20(out_r[6]), .out_r21(out_r[7]), .out_r22(out_r[8]),
    .out_singular(out_singular)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] sat_quotient(logic signed [127:0] adj,
                                               logic signed [127:0] det);
    logic [127:0] n;
    logic [127:0] d;
    logic [127:0] q;
    bit neg;
    neg = (adj < 0) != (det < 0);
    n = (adj < 0) ? -adj : adj;
    d = (det < 0) ? -det : det;
    q = (n << (FRAC + 16)) / d;
    if (neg) begin
      if (q > 128'h8000_0000) return mi3_pkg::SAT_NEG;
      return 32'(-q);
    end
    if (q > 128'h7FFF_FFFF) return mi3_pkg::SAT_POS;
    return q[31:0];
  endfunction

  function automatic inv_t adjugate_inverse(mat_t m);
    logic signed [127:0] e [9];
    logic signed [127:0] cf [9];
    logic signed [127:0] det;
    inv_t o;
    for (int k = 0; k < 9; k++) e[k] = 128'(m[k]);
    cf[0] = e[4] * e[8] - e[5] * e[7];
    cf[1] = e[5] * e[6] - e[3] * e[8];
    cf[2] = e[3] * e[7] - e[4] * e[6];
    cf[3] = e[2] * e[7] - e[1] * e[8];
    cf[4] = e[0] * e[8] - e[2] * e[6];
    cf[5] = e[1] * e[6] - e[0] * e[7];
    cf[6] = e[1] * e[5] - e[2] * e[4];
    cf[7] = e[2] * e[3] - e[0] * e[5];
    cf[8] = e[0] * e[4] - e[1] * e[3];
    det = e[0] * cf[0] + e[1] * cf[1] + e[2] * cf[2];
    o.sing = (det == 0);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        o.r[r * 3 + c] = o.sing ? 32'd0 : sat_quotient(cf[c * 3 + r], det);
    return o;
  endfunction

  function automatic row_t plain_row(mat_t m);
    row_t t;
    t.m = m;
    t.known = 1'b0;
    return t;
  endfunction

  function automatic row_t known_row(mat_t m, logic [31:0] v, logic s);
    row_t t;
    t.m = m;
    t.known = 1'b1;
    for (int k = 0; k < 9; k++) t.res.r[k] = v;
    t.res.sing = s;
    return t;
  endfunction

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 5))
      0: return elem_t'($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000);
      1: return elem_t'($signed($urandom_range(0, 8)) - 4);
      2: return elem_t'($signed($urandom_range(0, 1024)) - 512);
      default: return elem_t'($urandom);
    endcase
  endfunction

  function automatic mat_t rand_matrix();
    mat_t m;
    int a;
    int b;
    bit dup;
    for (int k = 0; k < 9; k++) m[k] = rand_elem();
    if ($urandom_range(0, 7) == 0) begin
      // duplicated row or zeroed column forces a zero determinant
      a = $urandom_range(0, 2);
      b = (a + 1 + $urandom_range(0, 1)) % 3;
      dup = $urandom_range(0, 1);
      for (int k = 0; k < 3; k++)
        if (dup) m[b * 3 + k] = m[a * 3 + k];
        else m[k * 3 + b] = 0;
    end else if ($urandom_range(0, 5) == 0) begin
      // diagonal with small pivots drives large inverse entries
      for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? elem_t'($urandom_range(1, 3)) : '0;
    end
    return m;
  endfunction

  task automatic send_matrix(row_t t);
    inv_t o;
    for (int k = 0; k < 9; k++) in_m[k] <= t.m[k];
    in_valid <= 1'b1;
    o = adjugate_inverse(t.m);
    inv_queue = {inv_queue, o};
    known_flag = {known_flag, t.known};
    known_queue = {known_queue, t.res};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic sender_gap();
    int g;
    g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  initial begin
    row_t dir [$];
    mat_t m;
    int burst;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    for (int k = 0; k < 9; k++) in_m[k] = '0;
    fails = 0;
    stim_done = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    m = '{default: '0};
    dir = {dir, known_row(m, 32'd0, 1'b1)};
    m = '{16'sh0100, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100};
    dir = {dir, plain_row(m)};
    m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    dir = {dir, plain_row(m)};
    m = '{-1, 0, 0, 0, -1, 0, 0, 0, -1};
    dir = {dir, plain_row(m)};
    m = '{default: 16'sh7FFF};
    dir = {dir, known_row(m, 32'd0, 1'b1)};
    m = '{default: 16'sh8000};
    dir = {dir, known_row(m, 32'd0, 1'b1)};
    m = '{16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0, 0, 0, 16'sh7FFF};
    dir = {dir, plain_row(m)};
    m = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000};
    dir = {dir, plain_row(m)};
    m = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
          16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF};
    dir = {dir, plain_row(m)};
    m = '{0, 0, 16'sh0100, 0, 16'sh0100, 0, 16'sh0100, 0, 0};
    dir = {dir, plain_row(m)};
    m = '{16'sh0200, 16'sh0100, 0, 16'sh0100, 16'sh0300, 16'sh0100,
          0, 16'sh0100, 16'sh0400};
    dir = {dir, plain_row(m)};
    m = '{1, 2, 3, 4, 5, 6, 7, 8, 9};
    dir = {dir, known_row(m, 32'd0, 1'b1)};
    m = '{1, 2, 3, 0, 1, 4, 5, 6, 0};
    dir = {dir, plain_row(m)};
    m = '{16'shFFFF, 16'sh5555, 16'shAAAA, 16'sh1234, 16'shEDCB,
          16'sh0F0F, 16'shF0F0, 16'sh00FF, 16'shFF00};
    dir = {dir, plain_row(m)};

    foreach (dir[j]) begin
      send_matrix(dir[j]);
      sender_gap();
    end
    in_valid <= 1'b0;
    while (inv_queue.size() > 0)
      @(posedge clk);

    for (int j = 0; j < NRAND; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && j < NRAND; b++, j++) begin
        m = rand_matrix();
        send_matrix(plain_row(m));
      end
      sender_gap();
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stall pattern: long free stretches and random stall runs
  initial begin
    int mode;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        @(posedge clk);
        out_stall <= (mode == 0) ? 1'b0 :
                     (mode == 1) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 1) == 1);
      end
    end
  end

  always @(posedge clk) begin
    inv_t want;
    bit kn;
    inv_t kv;
    if (rst_n && out_valid && !out_stall) begin
      if (inv_queue.size() == 0) begin
        $display("%0t unexpected transfer r00=%h", $time, out_r[0]);
        fails++;
      end else begin
        want = inv_queue.pop_front();
        kn = known_flag.pop_front();
        kv = known_queue.pop_front();
        if (kn && (kv.sing != want.sing || kv.r[0] != want.r[0])) begin
          $display("%0t predictor disagrees with table: exp sing=%b r00=%h act sing=%b r00=%h",
                   $time, kv.sing, kv.r[0], want.sing, want.r[0]);
          fails++;
        end
        for (int k = 0; k < 9; k++)
          if (out_r[k] !== want.r[k]) begin
            $display("%0t r%0d%0d exp %h act %h", $time, k / 3, k % 3, want.r[k], out_r[k]);
            fails++;
          end
        if (out_singular !== want.sing) begin
          $display("%0t singular exp %b act %b", $time, want.sing, out_singular);
          fails++;
        end
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYC_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
      if (stim_done && inv_queue.size() == 0) begin
        repeat (LATENCY + 10) @(posedge clk);
        if (fails == 0 && inv_queue.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
